/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks with an asynchronous active-low reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/swfe_pkg.sv */
// ----------------------------------------------------------------------------
// swfe_pkg
// shared constants and types of the sync word frame extractor
// ----------------------------------------------------------------------------
package swfe_pkg;

    localparam int SYNC_LENGTH   = 46;
    localparam int PATTERN_SLOTS = 64;
    localparam int CNT_W         = $clog2(SYNC_LENGTH + 1);
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 16;

    localparam logic [LEN_W-1:0] LEN_RESET = 16'd256;

    // sync pattern, unused slots expect zero
    localparam logic [BYTE_W-1:0] SYNC_PATTERN [PATTERN_SLOTS] = '{
        8'hEB, 8'h1F, 8'h5E, 8'h89, 8'h76, 8'h08, 8'h31, 8'hC0,
        8'h88, 8'h46, 8'h07, 8'h89, 8'h46, 8'h0C, 8'hB0, 8'h0B,
        8'h89, 8'hF3, 8'h8D, 8'h4E, 8'h08, 8'h8D, 8'h56, 8'h0C,
        8'hCD, 8'h80, 8'h31, 8'hDB, 8'h89, 8'hD8, 8'h40, 8'hCD,
        8'h80, 8'hE8, 8'hDC, 8'hFF, 8'hFF, 8'hFF, 8'h2F, 8'h62,
        8'h69, 8'h6E, 8'h2F, 8'h73, 8'h68, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic              vld;
        logic [BYTE_W-1:0] data;
    } in_item_t;

endpackage

/* hdl/swfe_in_stage.sv */
// ----------------------------------------------------------------------------
// swfe_in_stage
// input register that holds one received byte until the core takes it
// ----------------------------------------------------------------------------
module swfe_in_stage
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [swfe_pkg::BYTE_W-1:0]   in_byte,
    input  logic                          taken,
    output swfe_pkg::in_item_t            item
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [swfe_pkg::BYTE_W-1:0] data_reg;

    assign in_stall   = valid_reg && !taken;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            data_reg <= in_byte;
        end
    end

    assign item.vld  = valid_reg;
    assign item.data = data_reg;

endmodule

/* hdl/swfe_core.sv */
// ----------------------------------------------------------------------------
// swfe_core
// sync window, pattern compare, frame counter and result register
// ----------------------------------------------------------------------------
module swfe_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  swfe_pkg::in_item_t            item,
    output logic                          taken,
    input  logic                          cfg_valid,
    input  logic [swfe_pkg::LEN_W-1:0]    cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [swfe_pkg::BYTE_W-1:0]   out_byte,
    output logic                          first_of_frame,
    output logic                          last_of_frame
);

    logic [swfe_pkg::BYTE_W-1:0] window_reg  [swfe_pkg::SYNC_LENGTH];
    logic [swfe_pkg::BYTE_W-1:0] window_next [swfe_pkg::SYNC_LENGTH];
    logic [swfe_pkg::CNT_W-1:0]  cnt_reg;
    logic [swfe_pkg::CNT_W-1:0]  cnt_next;
    logic [swfe_pkg::CNT_W-1:0]  cnt_shift;
    logic                        in_payload_reg;
    logic                        in_payload_next;
    logic                        first_pending_reg;
    logic                        first_pending_next;
    logic [swfe_pkg::LEN_W-1:0]  bytes_left_reg;
    logic [swfe_pkg::LEN_W-1:0]  bytes_left_next;
    logic [swfe_pkg::LEN_W-1:0]  length_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [swfe_pkg::BYTE_W-1:0] out_byte_reg;
    logic                        first_reg;
    logic                        last_reg;
    logic                        out_free;
    logic                        is_last;
    logic                        pattern_eq;
    logic                        match;
    logic                        emit;

    assign out_free = !out_valid_reg || !out_stall;
    assign taken    = item.vld && (!in_payload_reg || out_free);
    assign emit     = taken && in_payload_reg;
    assign is_last  = (bytes_left_reg <= swfe_pkg::LEN_W'(1));

    // shift line with the new byte entering at the end
    always_comb
    begin
        for (int i = 0; i < swfe_pkg::SYNC_LENGTH - 1; i++)
        begin
            window_next[i] = window_reg[i + 1];
        end
        window_next[swfe_pkg::SYNC_LENGTH - 1] = item.data;
    end

    assign cnt_shift = (cnt_reg == swfe_pkg::CNT_W'(swfe_pkg::SYNC_LENGTH)) ?
                       cnt_reg : cnt_reg + swfe_pkg::CNT_W'(1);

    always_comb
    begin
        pattern_eq = 1'b1;
        for (int i = 0; i < swfe_pkg::SYNC_LENGTH; i++)
        begin
            if (window_next[i] != swfe_pkg::SYNC_PATTERN[i])
            begin
                pattern_eq = 1'b0;
            end
        end
    end

    assign match = pattern_eq && (cnt_shift == swfe_pkg::CNT_W'(swfe_pkg::SYNC_LENGTH));

    always_comb
    begin
        cnt_next           = cnt_reg;
        in_payload_next    = in_payload_reg;
        first_pending_next = first_pending_reg;
        bytes_left_next    = bytes_left_reg;
        if (taken)
        begin
            if (in_payload_reg)
            begin
                first_pending_next = 1'b0;
                bytes_left_next    = bytes_left_reg - swfe_pkg::LEN_W'(1);
                if (is_last)
                begin
                    in_payload_next = 1'b0;
                    cnt_next        = '0;
                    bytes_left_next = '0;
                end
            end
            else
            begin
                cnt_next = cnt_shift;
                if (match)
                begin
                    in_payload_next    = 1'b1;
                    first_pending_next = 1'b1;
                    bytes_left_next    = (length_reg == '0) ? swfe_pkg::LEN_W'(1) : length_reg;
                end
            end
        end
    end

    assign out_valid_next = emit ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg           <= '0;
            in_payload_reg    <= 1'b0;
            first_pending_reg <= 1'b0;
            bytes_left_reg    <= '0;
            length_reg        <= swfe_pkg::LEN_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            cnt_reg           <= cnt_next;
            in_payload_reg    <= in_payload_next;
            first_pending_reg <= first_pending_next;
            bytes_left_reg    <= bytes_left_next;
            out_valid_reg     <= out_valid_next;
            if (cfg_valid)
            begin
                length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (taken && !in_payload_reg)
        begin
            window_reg <= window_next;
        end
        if (emit)
        begin
            out_byte_reg <= item.data;
            first_reg    <= first_pending_reg;
            last_reg     <= is_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign first_of_frame = first_reg;
    assign last_of_frame  = last_reg;

endmodule

/* hdl/sync_word_frame_extractor_unit.sv */
// ----------------------------------------------------------------------------
// sync_word_frame_extractor_unit
// hunts for a 46-byte sync word in a byte stream and forwards the payload
// ----------------------------------------------------------------------------
// input channel in_valid/in_stall/in_byte takes one received byte per
// transaction; output channel out_valid/out_stall carries one payload byte
// with first_of_frame and last_of_frame. no result is given while hunting.
// config channel cfg_valid/cfg_ready/payload_length sets the frame length,
// latched at each sync match; a length of zero counts as one. cfg_ready is
// always high.
// a byte is held in the input register and is then handled by the window
// compare and frame counter, so a payload byte reaches the output through
// the input register and then the result register. one byte per cycle is
// sustained while out_stall holds no result; the 46-byte window compare is
// combinational and sets that rate.
// reset clears the window fill count, returns to hunting and sets the length to 256.
// while out_stall holds a result, hunting bytes keep flowing; a payload
// byte waits in the input register and in_stall rises.
// ----------------------------------------------------------------------------
module sync_word_frame_extractor_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [swfe_pkg::BYTE_W-1:0]   in_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [swfe_pkg::BYTE_W-1:0]   out_byte,
    output logic                          first_of_frame,
    output logic                          last_of_frame,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [swfe_pkg::LEN_W-1:0]    payload_length
);

    swfe_pkg::in_item_t item;
    logic               taken;

    assign cfg_ready = 1'b1;

    swfe_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .taken    (taken),
        .item     (item)
    );

    swfe_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .taken          (taken),
        .cfg_valid      (cfg_valid && cfg_ready),
        .cfg_data       (payload_length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame)
    );

endmodule

/* hdl/swfe_checker.sv */
// ----------------------------------------------------------------------------
// swfe_checker
// port-level checks of frame marking and output timing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swfe_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [swfe_pkg::BYTE_W-1:0]   out_byte,
    input logic                          first_of_frame,
    input logic                          last_of_frame
);

    logic expect_first_reg;
    logic out_xfer;
    logic in_xfer;

    assign out_xfer = out_valid && !out_stall;
    assign in_xfer  = in_valid && !in_stall;

    // a frame opens after reset and after every last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_first_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            expect_first_reg <= last_of_frame;
        end
    end

    `AST_IMPLIES(a_first_marking, clk, rst_n, out_valid, first_of_frame == expect_first_reg, "first_of_frame out of sequence")

    `AST_IMPLIES(a_out_from_input, clk, rst_n, $rose(out_valid), $past(in_xfer, 2), "result without an input transaction")

    `AST_NEXT(a_stall_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(first_of_frame) && $stable(last_of_frame), "stalled result changed")

endmodule

bind sync_word_frame_extractor_unit swfe_checker u_swfe_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .first_of_frame (first_of_frame),
    .last_of_frame  (last_of_frame)
);

/* bench/sync_word_frame_extractor_checker.sv */
// ----------------------------------------------------------------------------
// sync_word_frame_extractor_checker
// watches the byte, payload and config channels of the frame extractor,
// predicts every payload byte with its frame flags from the accepted bytes
// and compares each output transaction with the oldest prediction
// ----------------------------------------------------------------------------
module sync_word_frame_extractor_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic        first_of_frame,
    input  logic        last_of_frame,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] payload_length,
    output int          pending,
    output int          fail_count,
    output int          frames_done,
    output int          bytes_out
);

    localparam int SYNC_BYTES = 46;

    // 38 code bytes, "/bin/sh", trailing zero
    localparam logic [7:0] SYNC_WORD [SYNC_BYTES] = '{
        8'hEB, 8'h1F, 8'h5E, 8'h89, 8'h76, 8'h08, 8'h31, 8'hC0,
        8'h88, 8'h46, 8'h07, 8'h89, 8'h46, 8'h0C, 8'hB0, 8'h0B,
        8'h89, 8'hF3, 8'h8D, 8'h4E, 8'h08, 8'h8D, 8'h56, 8'h0C,
        8'hCD, 8'h80, 8'h31, 8'hDB, 8'h89, 8'hD8, 8'h40, 8'hCD,
        8'h80, 8'hE8, 8'hDC, 8'hFF, 8'hFF, 8'hFF, "/",   "b",
        "i",   "n",   "/",   "s",   "h",   8'h00
    };

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
        logic       eof;
    } payload_beat_t;

    payload_beat_t expected_beats [$];

    logic [7:0]  window_q [SYNC_BYTES];
    int          fill_level;
    logic        framing;
    logic [15:0] bytes_to_go;
    logic        first_due;
    logic [15:0] frame_len;

    function void clear_window();
        int i;
        for (i = 0; i < SYNC_BYTES; i++)
            window_q[i] = 8'h00;
        fill_level = 0;
    endfunction

    function void absorb_byte(input logic [7:0] b);
        payload_beat_t beat;
        logic          hit;
        int            i;
        if (framing)
        begin
            beat.data = b;
            beat.sof  = first_due;
            first_due = 1'b0;
            if (bytes_to_go > 0)
                bytes_to_go--;
            beat.eof = (bytes_to_go == 0);
            if (beat.eof)
            begin
                framing = 1'b0;
                clear_window();
            end
            expected_beats.insert(expected_beats.size(), beat);
        end
        else
        begin
            if (fill_level < SYNC_BYTES)
            begin
                window_q[fill_level] = b;
                fill_level++;
            end
            else
            begin
                for (i = 0; i < SYNC_BYTES - 1; i++)
                    window_q[i] = window_q[i + 1];
                window_q[SYNC_BYTES - 1] = b;
            end
            hit = (fill_level == SYNC_BYTES);
            for (i = 0; i < SYNC_BYTES; i++)
                if (window_q[i] != SYNC_WORD[i])
                    hit = 1'b0;
            if (hit)
            begin
                framing     = 1'b1;
                bytes_to_go = (frame_len == 0) ? 16'd1 : frame_len;
                first_due   = 1'b1;
            end
        end
    endfunction

    function void check_beat();
        payload_beat_t want;
        bytes_out++;
        if (last_of_frame === 1'b1)
            frames_done++;
        if (expected_beats.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected payload byte %02h first %0b last %0b",
                         out_byte, first_of_frame, last_of_frame);
        end
        else
        begin
            want = expected_beats.pop_front();
            if (out_byte !== want.data || first_of_frame !== want.sof ||
                last_of_frame !== want.eof)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                             want.data, want.sof, want.eof,
                             out_byte, first_of_frame, last_of_frame);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_window();
            framing     = 1'b0;
            bytes_to_go = 16'd0;
            first_due   = 1'b0;
            frame_len   = 16'd256;
            expected_beats.delete();
            pending     = 0;
            fail_count  = 0;
            frames_done = 0;
            bytes_out   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                frame_len = payload_length;
            if (out_valid && !out_stall)
                check_beat();
            if (in_valid && !in_stall)
                absorb_byte(in_byte);
            pending = expected_beats.size();
        end
    end

endmodule

/* bench/sync_word_frame_extractor_unit_tb.sv */
// ----------------------------------------------------------------------------
// sync_word_frame_extractor_unit_tb
// drives byte streams of sync words, broken sync words, noise and payloads
// through the frame extractor under several frame lengths, with random gaps
// and output stalls; the checker module predicts and compares every payload
// transaction and this top gives the verdict
// ----------------------------------------------------------------------------
module sync_word_frame_extractor_unit_tb;

    localparam int IDLE_LIMIT  = 4000;
    localparam int ITEM_TARGET = 660;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        first_of_frame;
    logic        last_of_frame;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] payload_length;

    int pending;
    int fail_count;
    int frames_done;
    int bytes_out;
    int items_sent;
    int cfg_writes;
    int idle_cycles = 0;
    bit calm;

    sync_word_frame_extractor_unit dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .payload_length (payload_length)
    );

    sync_word_frame_extractor_checker frame_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .payload_length (payload_length),
        .pending        (pending),
        .fail_count     (fail_count),
        .frames_done    (frames_done),
        .bytes_out      (bytes_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    initial
    begin
        int run_len;
        int hold;
        out_stall = 1'b0;
        forever
        begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 6);
            repeat (run_len)
            begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
            hold = pick_gap();
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(negedge clk);
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = calm ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        items_sent++;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_byte($urandom_range(0, 255));
    endtask

    // sync word bytes lo..hi, one bit flipped at flip_pos if it is in range
    task automatic send_sync_range(input int lo, input int hi, input int flip_pos);
        logic [7:0] b;
        int         i;
        for (i = lo; i <= hi; i++)
        begin
            b = swfe_pkg::SYNC_PATTERN[i];
            if (i == flip_pos)
                b = b ^ (8'h01 << $urandom_range(0, 7));
            send_byte(b);
        end
    endtask

    task automatic set_frame_len(input logic [15:0] len);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_valid      <= 1'b1;
        payload_length <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    initial
    begin
        int r;
        int len;
        int bursts;
        int k;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_byte        = 8'h00;
        cfg_valid      = 1'b0;
        payload_length = 16'd0;
        items_sent     = 0;
        cfg_writes     = 0;
        calm           = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset length of 256, window shifting past a broken prefix
        send_byte(8'h00);
        send_byte(8'hFF);
        send_sync_range(0, 29, -1);
        send_byte(8'h00);
        send_sync_range(0, 45, -1);
        send_byte(8'h00);
        send_random(254);
        send_byte(8'hFF);

        // zero length acts as one, back-to-back one-byte frames
        set_frame_len(16'd0);
        send_sync_range(0, 45, -1);
        send_byte(8'hA5);
        send_sync_range(0, 45, -1);
        send_byte(8'h5A);

        set_frame_len(16'd2);
        send_sync_range(0, 45, -1);
        send_byte(8'h00);
        send_byte(8'hFF);

        // sync word split across the frame end must not match
        set_frame_len(16'd20);
        send_sync_range(0, 45, -1);
        send_sync_range(0, 19, -1);
        send_sync_range(20, 45, -1);
        send_sync_range(0, 45, -1);
        send_random(20);

        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                len = $urandom_range(0, 1);
            else if (r < 70)
                len = $urandom_range(2, 12);
            else if (r < 93)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(41, 90);
            set_frame_len(len[15:0]);
            bursts = $urandom_range(1, 3);
            for (k = 0; k < bursts && items_sent < ITEM_TARGET; k++)
            begin
                calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) < 20)
                    send_sync_range(0, $urandom_range(0, 44), -1);
                send_random($urandom_range(0, 6));
                if ($urandom_range(0, 99) < 18)
                begin
                    send_sync_range(0, 45, $urandom_range(0, 45));
                    send_random($urandom_range(1, 8));
                end
                else
                begin
                    send_sync_range(0, 45, -1);
                    send_random((len == 0) ? 1 : len);
                end
            end
            calm = 1'b0;
        end

        // largest length, frame opened and left running
        set_frame_len(16'hFFFF);
        calm = 1'b1;
        send_sync_range(0, 45, -1);
        send_random(8);
        calm = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("sent %0d bytes under %0d frame length writes (0 up to 65535)",
                 items_sent, cfg_writes);
        $display("received %0d payload bytes in %0d frames", bytes_out, frames_done);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/swfe_pkg.sv
hdl/swfe_in_stage.sv
hdl/swfe_core.sv
hdl/sync_word_frame_extractor_unit.sv
hdl/swfe_checker.sv
bench/sync_word_frame_extractor_checker.sv
bench/sync_word_frame_extractor_unit_tb.sv
